// ===== rtl/core/rmae_pkg.sv =====
// -----------------------------------------------------------------------------
// rmae_pkg: shared types and constants of the remote memory atomic engine
// Request and response payloads, operation and status codes, controller
// states and the command/status bundles between controller and datapath.
// -----------------------------------------------------------------------------
package rmae_pkg;

   // default geometry of the paged store
   localparam int DEF_PAGE_COUNT = 64;
   localparam int DEF_PAGE_BYTES = 4096;

   // request field widths
   localparam int OP_W     = 3;
   localparam int PAGE_W   = 6;
   localparam int OFFSET_W = 12;
   localparam int SIZE_W   = 4;
   localparam int DATA_W   = 64;
   localparam int ID_W     = 32;

   // byte lane bits within one 64-bit word
   localparam int LANE_W = 3;

   // operation codes
   localparam logic [OP_W-1:0] OP_READ  = 3'd0;
   localparam logic [OP_W-1:0] OP_WRITE = 3'd1;
   localparam logic [OP_W-1:0] OP_ADD   = 3'd2;
   localparam logic [OP_W-1:0] OP_CAS   = 3'd3;
   localparam logic [OP_W-1:0] OP_TAKE  = 3'd4;
   localparam logic [OP_W-1:0] OP_COUNT = 3'd5;

   // access sizes
   localparam logic [SIZE_W-1:0] SIZE_1 = 4'd1;
   localparam logic [SIZE_W-1:0] SIZE_2 = 4'd2;
   localparam logic [SIZE_W-1:0] SIZE_4 = 4'd4;
   localparam logic [SIZE_W-1:0] SIZE_8 = 4'd8;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_BAD_SIZE   = 2'd1,
      STATUS_NO_PENDING = 2'd2,
      STATUS_MISALIGNED = 2'd3
   } status_type;

   typedef struct packed {
      logic [OP_W-1:0]     operation;
      logic [PAGE_W-1:0]   page;
      logic [OFFSET_W-1:0] offset;
      logic [SIZE_W-1:0]   size;
      logic [DATA_W-1:0]   value;
      logic [DATA_W-1:0]   compare_value;
   } req_type;

   typedef struct packed {
      status_type        status;
      logic [DATA_W-1:0] read_data;
      logic [ID_W-1:0]   transaction_id;
      logic [ID_W-1:0]   pending_count;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_INDEX,
      ST_ADDR,
      ST_EXEC
   } ctl_state_type;

   // controller to datapath
   typedef struct packed {
      logic clear;
      logic capture;
      logic decode;
      logic index;
      logic addr;
      logic exec;
   } ctl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_done;
      logic mem_go;
   } dp_stat_type;

   // byte mask of an access of the given size (valid sizes only)
   function automatic logic [DATA_W-1:0] lane_mask(input logic [SIZE_W-1:0] size);
      logic [DATA_W-1:0] mask;
      unique case (size)
         SIZE_1:  mask = 64'h0000_0000_0000_00FF;
         SIZE_2:  mask = 64'h0000_0000_0000_FFFF;
         SIZE_4:  mask = 64'h0000_0000_FFFF_FFFF;
         default: mask = 64'hFFFF_FFFF_FFFF_FFFF;
      endcase
      return mask;
   endfunction

endpackage

// ===== rtl/core/rmae_ram.sv =====
// -----------------------------------------------------------------------------
// rmae_ram: generic single-clock RAM
// One write port and one read port, read data registered.
// -----------------------------------------------------------------------------
module rmae_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 32768,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/rmae_ctrl.sv =====
// -----------------------------------------------------------------------------
// rmae_ctrl: sequencing controller
// Runs the post-reset clearing pass, then steps each accepted transaction
// through decode and execute, with address build and store read between them for valid memory accesses.
// -----------------------------------------------------------------------------
module rmae_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  rmae_pkg::dp_stat_type stat,
   output rmae_pkg::ctl_cmd_type cmd
);

   rmae_pkg::ctl_state_type state_ff;
   rmae_pkg::ctl_state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rmae_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      unique case (state_ff)
         rmae_pkg::ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (stat.clear_done) begin
               state_in = rmae_pkg::ST_IDLE;
            end
         end
         rmae_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = rmae_pkg::ST_DECODE;
            end
         end
         rmae_pkg::ST_DECODE: begin
            cmd.decode = 1'b1;
            // only valid memory accesses touch the store
            state_in = stat.mem_go ? rmae_pkg::ST_INDEX : rmae_pkg::ST_EXEC;
         end
         rmae_pkg::ST_INDEX: begin
            cmd.index = 1'b1;
            state_in  = rmae_pkg::ST_ADDR;
         end
         rmae_pkg::ST_ADDR: begin
            cmd.addr = 1'b1;
            state_in = rmae_pkg::ST_EXEC;
         end
         rmae_pkg::ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = rmae_pkg::ST_IDLE;
         end
         default: begin
            state_in = rmae_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/core/rmae_dpath.sv =====
// -----------------------------------------------------------------------------
// rmae_dpath: datapath of the atomic engine
// Request register, page/word index arithmetic, store RAM with clearing
// counter, lane merge for read/write/add/compare-swap, id counters and the
// response register.
// -----------------------------------------------------------------------------
module rmae_dpath #(
   parameter int PAGE_COUNT = rmae_pkg::DEF_PAGE_COUNT,
   parameter int PAGE_BYTES = rmae_pkg::DEF_PAGE_BYTES
) (
   input  logic                  clock,
   input  logic                  reset,
   input  rmae_pkg::req_type     req_payload,
   input  rmae_pkg::ctl_cmd_type cmd,
   output rmae_pkg::dp_stat_type stat,
   output logic                  rsp_valid,
   output rmae_pkg::rsp_type     rsp_payload
);

   localparam int DATA_W         = rmae_pkg::DATA_W;
   localparam int ID_W           = rmae_pkg::ID_W;
   localparam int PAGE_W         = rmae_pkg::PAGE_W;
   localparam int LANE_W         = rmae_pkg::LANE_W;
   localparam int WORDS_PER_PAGE = PAGE_BYTES / 8;
   localparam int STORE_DEPTH    = PAGE_COUNT * WORDS_PER_PAGE;
   localparam int ADDR_W         = $clog2(STORE_DEPTH);
   localparam int PAGE_SPAN      = 2 ** PAGE_W;
   // word select taken from the raw offset
   localparam int WSEL_W         = rmae_pkg::OFFSET_W - LANE_W;
   // reciprocal for the word-in-page remainder, exact for WSEL_W-bit values
   localparam int WPP_LOG        = $clog2(WORDS_PER_PAGE);
   localparam int RECIP_SHIFT    = WSEL_W + WPP_LOG;
   localparam int RECIP          = (2 ** RECIP_SHIFT + WORDS_PER_PAGE - 1) / WORDS_PER_PAGE;
   localparam int RECIP_W        = WSEL_W + 2;
   localparam int PROD_W         = WSEL_W + RECIP_W;
   localparam int SUB_W          = WSEL_W + ADDR_W + 1;

   // request register
   rmae_pkg::req_type req_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_payload;
      end
   end

   // request checks
   logic              size_ok;
   logic              aligned;
   logic              mem_op;
   rmae_pkg::status_type chk_status;

   always_comb begin
      size_ok = (req_ff.size == rmae_pkg::SIZE_1) || (req_ff.size == rmae_pkg::SIZE_2) ||
                (req_ff.size == rmae_pkg::SIZE_4) || (req_ff.size == rmae_pkg::SIZE_8);
      // page size is a multiple of 8, so the raw offset sets the alignment
      unique case (req_ff.size)
         rmae_pkg::SIZE_2: aligned = (req_ff.offset[0] == 1'b0);
         rmae_pkg::SIZE_4: aligned = (req_ff.offset[1:0] == 2'b00);
         rmae_pkg::SIZE_8: aligned = (req_ff.offset[2:0] == 3'b000);
         default:          aligned = 1'b1;
      endcase
      mem_op = (req_ff.operation == rmae_pkg::OP_READ)  ||
               (req_ff.operation == rmae_pkg::OP_WRITE) ||
               (req_ff.operation == rmae_pkg::OP_ADD)   ||
               (req_ff.operation == rmae_pkg::OP_CAS);
      if (!size_ok) begin
         chk_status = rmae_pkg::STATUS_BAD_SIZE;
      end else if (!aligned) begin
         chk_status = rmae_pkg::STATUS_MISALIGNED;
      end else begin
         chk_status = rmae_pkg::STATUS_OK;
      end
   end

   assign stat.mem_go = mem_op && (chk_status == rmae_pkg::STATUS_OK);

   // page number modulo page count, constant table
   logic [PAGE_W-1:0] page_lut [PAGE_SPAN];

   for (genvar p = 0; p < PAGE_SPAN; p++) begin : g_page_lut
      assign page_lut[p] = PAGE_W'(p % PAGE_COUNT);
   end

   // decode step: page remainder and word quotient
   logic [WSEL_W-1:0]  wsel;
   logic [PROD_W-1:0]  wq_prod;
   logic [PAGE_W-1:0]  page_mod_ff;
   logic [WSEL_W-1:0]  wq_ff;

   assign wsel    = req_ff.offset[rmae_pkg::OFFSET_W-1:LANE_W];
   assign wq_prod = PROD_W'(wsel) * PROD_W'(RECIP);

   always_ff @(posedge clock) begin
      if (cmd.decode) begin
         page_mod_ff <= page_lut[req_ff.page];
         wq_ff       <= WSEL_W'(wq_prod >> RECIP_SHIFT);
      end
   end

   // index step: page base and word within page
   logic [ADDR_W-1:0] page_base_ff;
   logic [ADDR_W-1:0] word_off_ff;
   logic [SUB_W-1:0]  word_rem;

   assign word_rem = SUB_W'(wsel) - SUB_W'(wq_ff) * SUB_W'(WORDS_PER_PAGE);

   always_ff @(posedge clock) begin
      if (cmd.index) begin
         page_base_ff <= ADDR_W'(ADDR_W'(page_mod_ff) * ADDR_W'(WORDS_PER_PAGE));
         word_off_ff  <= ADDR_W'(word_rem);
      end
   end

   // address step: word address, kept for the write back
   logic [ADDR_W-1:0] word_addr;
   logic [ADDR_W-1:0] addr_ff;

   assign word_addr = page_base_ff + word_off_ff;

   always_ff @(posedge clock) begin
      if (cmd.addr) begin
         addr_ff <= word_addr;
      end
   end

   // clearing sweep after reset
   logic [ADDR_W-1:0] clear_cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_cnt_ff <= '0;
      end else if (cmd.clear) begin
         clear_cnt_ff <= clear_cnt_ff + 1'b1;
      end
   end

   assign stat.clear_done = (clear_cnt_ff == ADDR_W'(STORE_DEPTH - 1));

   // execute step: lane extract, modify, merge
   logic [DATA_W-1:0] word;
   logic [DATA_W-1:0] mask;
   logic [5:0]        shamt;
   logic [DATA_W-1:0] old_val;
   logic [DATA_W-1:0] sum_val;
   logic              cas_hit;
   logic [DATA_W-1:0] new_val;
   logic              do_write;
   logic [DATA_W-1:0] new_word;
   logic [DATA_W-1:0] mem_rdata;

   always_comb begin
      mask     = rmae_pkg::lane_mask(req_ff.size);
      shamt    = {req_ff.offset[LANE_W-1:0], 3'b000};
      old_val  = (word >> shamt) & mask;
      sum_val  = (old_val + req_ff.value) & mask;
      cas_hit  = (old_val == (req_ff.compare_value & mask));
      new_val  = req_ff.value & mask;
      do_write = 1'b0;
      mem_rdata = '0;
      unique case (req_ff.operation)
         rmae_pkg::OP_READ: begin
            mem_rdata = old_val;
         end
         rmae_pkg::OP_WRITE: begin
            do_write = 1'b1;
         end
         rmae_pkg::OP_ADD: begin
            mem_rdata = old_val;
            new_val   = sum_val;
            do_write  = 1'b1;
         end
         rmae_pkg::OP_CAS: begin
            mem_rdata = {{(DATA_W-1){1'b0}}, cas_hit};
            do_write  = cas_hit;
         end
         default: begin
            do_write = 1'b0;
         end
      endcase
      new_word = (word & ~(mask << shamt)) | (new_val << shamt);
   end

   // store
   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic [DATA_W-1:0] ram_wr_data;

   assign ram_wr_en   = cmd.clear || (cmd.exec && stat.mem_go && do_write);
   assign ram_wr_addr = cmd.clear ? clear_cnt_ff : addr_ff;
   assign ram_wr_data = cmd.clear ? '0 : new_word;

   rmae_ram #(
      .WIDTH (DATA_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (cmd.addr),
      .rd_addr (word_addr),
      .rd_data (word)
   );

   // transaction counters and response
   logic [ID_W-1:0]   next_id_ff;
   logic [ID_W-1:0]   pend_ff;
   logic [ID_W-1:0]   next_id_in;
   logic [ID_W-1:0]   pend_in;
   logic              rsp_valid_ff;
   rmae_pkg::rsp_type rsp_ff;
   rmae_pkg::rsp_type rsp_in;

   always_comb begin
      next_id_in            = next_id_ff;
      pend_in               = pend_ff;
      rsp_in.status         = rmae_pkg::STATUS_OK;
      rsp_in.read_data      = '0;
      rsp_in.transaction_id = '0;
      if (mem_op) begin
         next_id_in            = next_id_ff + 1'b1;
         pend_in               = pend_ff + 1'b1;
         rsp_in.transaction_id = next_id_ff;
         rsp_in.status         = chk_status;
         if (stat.mem_go) begin
            rsp_in.read_data = mem_rdata;
         end
      end else if (req_ff.operation == rmae_pkg::OP_TAKE) begin
         if (pend_ff != '0) begin
            rsp_in.transaction_id = next_id_ff - pend_ff;
            pend_in               = pend_ff - 1'b1;
         end else begin
            rsp_in.status = rmae_pkg::STATUS_NO_PENDING;
         end
      end else if (req_ff.operation == rmae_pkg::OP_COUNT) begin
         rsp_in.read_data = DATA_W'(pend_ff);
      end
      rsp_in.pending_count = pend_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_id_ff   <= '0;
         pend_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.exec;
         if (cmd.exec) begin
            next_id_ff <= next_id_in;
            pend_ff    <= pend_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ===== rtl/core/remote_memory_atomic_engine_core.sv =====
// -----------------------------------------------------------------------------
// remote_memory_atomic_engine_core: paged remote store with atomic operations
// After reset the block clears its store, all PAGE_COUNT*PAGE_BYTES/8 words
// (32768 at the defaults), with busy high. A transaction is taken when start is
// high and busy is low. Its result appears on rsp_payload for exactly one
// cycle with rsp_valid high and cannot be stalled, so the receiver must take
// it then. Word read, write, atomic add and compare-swap with a good size and
// alignment pass from acceptance to the result strobe through decode with a
// reciprocal multiply for the page/word index, index build, one registered
// read of the store, then modify and write back; all others skip the index and
// store read. A new transaction may be accepted in the result strobe cycle.
// -----------------------------------------------------------------------------
module remote_memory_atomic_engine_core #(
   parameter int PAGE_COUNT = rmae_pkg::DEF_PAGE_COUNT,
   parameter int PAGE_BYTES = rmae_pkg::DEF_PAGE_BYTES
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  rmae_pkg::req_type req_payload,
   output logic              rsp_valid,
   output rmae_pkg::rsp_type rsp_payload
);

   rmae_pkg::ctl_cmd_type cmd;
   rmae_pkg::dp_stat_type stat;

   // controller
   rmae_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   // datapath
   rmae_dpath #(
      .PAGE_COUNT (PAGE_COUNT),
      .PAGE_BYTES (PAGE_BYTES)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

endmodule
